@@ rtl/core/lmdc_pkg.sv @@
package lmdc_pkg;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ENABLE = 2'd0;
    localparam t_cfg_idx CFG_RATE   = 2'd1;
    localparam t_cfg_idx CFG_DEPTH  = 2'd2;

    localparam int CFG_DATA_W = 7;

    localparam logic       ENABLE_RST = 1'b0;
    localparam logic [6:0] RATE_RST   = 7'd8;
    localparam logic [6:0] DEPTH_RST  = 7'd127;

    localparam int          LFO_STEP_NUM = 32'h1FFF;
    localparam logic [15:0] FRAC_ONE     = 16'hFFFF;
    localparam int          SINE_AMP     = 32767;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_POS,
        S_TAP0,
        S_TAP1,
        S_SUM1,
        S_DIV,
        S_RD0,
        S_RD1,
        S_MUL1,
        S_ACC,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_urem_stat;

    // Rounded sine entry, halves rounded away from zero. The step is the angle between entries.
    function automatic logic signed [15:0] sine_value(input int k, input real step);
        real ang;
        real s;
        real mag;
        int  m;
        ang = step * real'(k);
        s   = $sin(ang);
        mag = real'(SINE_AMP) * ((s < 0.0) ? -s : s) + 0.5 + 1.0e-9;
        m   = $rtoi(mag);
        return (s < 0.0) ? 16'(-m) : 16'(m);
    endfunction

endpackage

@@ rtl/core/lfo_modulated_delay_chorus_unit.sv @@
// Flow: a disabled beat goes from idle straight to the output stage. An enabled beat
// first passes the position, tap, wrap, read, multiply and accumulate states, with the
// tap positions wrapped bit-serially. No new beat is taken until the block is back in
// idle, and the output stage holds while an untaken result is in the output register;
// a finished result waits there while the next beat runs. Reset: synchronous, active low.
// A clearing pass then zeroes the delay memory, one entry a cycle, before the first beat.
module lfo_modulated_delay_chorus_unit #(
    parameter int DELAY_DEPTH    = 1024,
    parameter int LFO_TABLE_LEN  = 256,
    parameter int SAMPLE_RATE_HZ = 48000
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  lmdc_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [lmdc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [31:0]                     i_s_axis_tdata,  // sample_in[31:0]
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [31:0]                     o_m_axis_tdata   // sample_out[31:0]
);
    import lmdc_pkg::*;

    localparam int AW      = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int LW      = (LFO_TABLE_LEN > 1) ? $clog2(LFO_TABLE_LEN) : 1;
    localparam int PHW     = LW + 16;
    localparam int CMW     = 7 + $clog2(DELAY_DEPTH + 1);
    localparam int SPW     = 16 + AW + 1;
    localparam int STEP_K  = (LFO_STEP_NUM * LFO_TABLE_LEN) / SAMPLE_RATE_HZ;
    localparam logic [PHW:0] PHASE_MOD = (PHW + 1)'(LFO_TABLE_LEN) << 16;
    localparam real SINE_STEP = 2.0 * 3.14159265358979323846 / real'(LFO_TABLE_LEN);

    typedef logic signed [15:0] t_sine_rom [LFO_TABLE_LEN];

    function automatic t_sine_rom build_sine();
        t_sine_rom tab;
        for (int k = 0; k < LFO_TABLE_LEN; k++) begin
            tab[k] = sine_value(k, SINE_STEP);
        end
        return tab;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine();

    t_state r_state;
    t_state n_state;

    logic        r_cfg_enable;
    logic [6:0]  r_cfg_rate;
    logic [6:0]  r_cfg_depth;

    logic [31:0]           mem [DELAY_DEPTH];
    logic [31:0]           r_mem_q;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [31:0]           mem_wdata;
    logic [AW-1:0]         rd_addr;
    logic [LW-1:0]         rom_addr;
    logic signed [15:0]    r_sine_q;

    logic [AW-1:0]         r_clr;
    logic [AW-1:0]         r_wp;
    logic [AW-1:0]         n_wp;
    logic [PHW-1:0]        r_phase;
    logic [31:0]           r_x;
    logic                  r_en_item;
    logic [AW-1:0]         r_center;
    logic [AW:0]           r_wrap;
    logic [CMW-1:0]        depth_prod;
    logic signed [SPW-1:0] r_prod;
    logic signed [SPW-1:0] tap_s;
    logic [AW:0]           tap_sum;
    logic [AW:0]           r_sum0;
    logic signed [32:0]    r_pw;
    logic signed [33:0]    r_wet;
    logic [LW-1:0]         idx;
    logic [LW-1:0]         nidx;
    logic [15:0]           frac;
    logic [PHW:0]          phase_sum;
    logic [PHW-1:0]        n_phase;

    logic                  urem_start;
    logic [AW:0]           w_rem0;
    logic [AW:0]           w_rem1;
    t_urem_stat            w_stat0;
    t_urem_stat            w_stat1;

    logic                  in_acc;
    logic                  out_load;
    logic signed [33:0]    wet_adj;
    logic signed [33:0]    wet_half;
    logic signed [32:0]    dry_ext;
    logic signed [32:0]    dry_adj;
    logic signed [32:0]    dry_half;
    logic signed [33:0]    res;
    logic [31:0]           result;
    logic                  r_out_valid;
    logic [31:0]           r_out_data;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load = (r_state == S_EMIT) && (!r_out_valid || i_m_axis_tready);

    assign idx  = r_phase[PHW-1:16];
    assign nidx = (idx == LW'(LFO_TABLE_LEN - 1)) ? '0 : idx + 1'b1;
    assign frac = r_phase[15:0];

    assign depth_prod = CMW'(r_cfg_depth) * CMW'(DELAY_DEPTH);
    assign n_wp       = (r_wp == '0) ? AW'({r_center, 1'b0}) : r_wp - 1'b1;

    assign tap_s   = (r_prod >>> 15) + $signed({{(SPW - AW){1'b0}}, r_center});
    assign tap_sum = {1'b0, r_wp} + {1'b0, tap_s[AW-1:0]};

    assign phase_sum = {1'b0, r_phase} + (PHW + 1)'(PHW'(STEP_K) * PHW'(r_cfg_rate));
    assign n_phase   = (phase_sum >= PHASE_MOD) ? PHW'(phase_sum - PHASE_MOD) : PHW'(phase_sum);

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_enable <= ENABLE_RST;
            r_cfg_rate   <= RATE_RST;
            r_cfg_depth  <= DEPTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLE: r_cfg_enable <= i_cfg_data[0];
                CFG_RATE:   r_cfg_rate   <= i_cfg_data;
                CFG_DEPTH:  r_cfg_depth  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(DELAY_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = r_cfg_enable ? S_POS : S_EMIT;
                end
            end
            S_POS:  n_state = S_TAP0;
            S_TAP0: n_state = S_TAP1;
            S_TAP1: n_state = S_SUM1;
            S_SUM1: n_state = S_DIV;
            S_DIV: begin
                if (w_stat0.done) begin
                    n_state = S_RD0;
                end
            end
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_MUL1;
            S_MUL1: n_state = S_ACC;
            S_ACC:  n_state = S_EMIT;
            S_EMIT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = r_clr;
        mem_wdata       = '0;
        rd_addr         = w_rem0[AW-1:0];
        rom_addr        = idx;
        urem_start      = 1'b0;
        unique case (r_state)
            S_CLEAR: mem_we = 1'b1;
            S_IDLE:  o_s_axis_tready = 1'b1;
            S_POS: begin
                mem_we    = 1'b1;
                mem_waddr = n_wp;
                mem_wdata = r_x;
            end
            S_TAP0:  rom_addr = nidx;
            S_SUM1:  urem_start = 1'b1;
            S_RD1:   rd_addr = w_rem1[AW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_wp        <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == S_POS) begin
                r_wp <= n_wp;
            end
            if (r_state == S_ACC) begin
                r_phase <= n_phase;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q  <= mem[rd_addr];
        r_sine_q <= SINE_ROM[rom_addr];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x       <= i_s_axis_tdata;
            r_en_item <= r_cfg_enable;
            r_center  <= AW'(depth_prod >> 8);
            r_wrap    <= (AW + 1)'({AW'(depth_prod >> 8), 1'b1});
        end
        case (r_state)
            S_TAP0: r_prod <= r_sine_q * $signed({1'b0, r_center});
            S_TAP1: begin
                r_sum0 <= tap_sum;
                r_prod <= r_sine_q * $signed({1'b0, r_center});
            end
            S_RD1:  r_pw <= $signed(r_mem_q[31:16]) * $signed({1'b0, FRAC_ONE - frac});
            S_MUL1: begin
                r_wet <= 34'(r_pw);
                r_pw  <= $signed(r_mem_q[31:16]) * $signed({1'b0, frac});
            end
            S_ACC:  r_wet <= r_wet + 34'(r_pw);
            default: ;
        endcase
        if (out_load) begin
            r_out_data <= result;
        end
    end

    always_comb begin
        wet_adj  = r_wet + $signed({33'd0, r_wet[33]});
        wet_half = wet_adj >>> 1;
        dry_ext  = {r_x[31], r_x};
        dry_adj  = dry_ext + $signed({32'd0, r_x[31]});
        dry_half = dry_adj >>> 1;
        res      = wet_half + 34'(dry_half);
        result   = r_en_item ? res[31:0] : r_x;
    end

    lmdc_urem #(
        .NW (AW + 1),
        .DW (AW + 1)
    ) u_urem0 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (urem_start),
        .i_dividend (r_sum0),
        .i_divisor  (r_wrap),
        .o_rem      (w_rem0),
        .o_stat     (w_stat0)
    );

    lmdc_urem #(
        .NW (AW + 1),
        .DW (AW + 1)
    ) u_urem1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (urem_start),
        .i_dividend (tap_sum),
        .i_divisor  (r_wrap),
        .o_rem      (w_rem1),
        .o_stat     (w_stat1)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_bypass_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_cfg_enable) |=> (r_state == S_EMIT))
        else $error("Disabled beat did not go straight to the output stage.");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD0) |-> ((w_rem0 < r_wrap) && (w_rem1 < r_wrap)))
        else $error("Tap position is not below the delay line length.");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ((w_stat0 == w_stat1) && (w_stat0.busy || w_stat0.done)))
        else $error("Tap wrap units are out of step.");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_phase} < PHASE_MOD)
        else $error("LFO phase left its range.");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == S_EMIT))
        else $error("Output beat appeared outside the output stage.");

endmodule

@@ rtl/core/lmdc_urem.sv @@
module lmdc_urem #(
    parameter int NW = 11,
    parameter int DW = 11
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [NW-1:0]          i_dividend,
    input  logic [DW-1:0]          i_divisor,
    output logic [DW-1:0]          o_rem,
    output lmdc_pkg::t_urem_stat   o_stat
);
    import lmdc_pkg::*;

    localparam int CNTW = (NW > 1) ? $clog2(NW) : 1;

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [NW-1:0]   r_dvd;
    logic [DW-1:0]   r_div;
    logic [DW-1:0]   r_rem;
    logic [DW:0]     trial;
    logic [DW-1:0]   n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[NW-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = DW'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_rem       = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import lmdc_pkg::*;

    localparam int DELAY_WORDS   = 1024;
    localparam int SINE_LEN      = 256;
    localparam int RATE_HZ       = 48000;
    localparam int LFO_STEP      = (LFO_STEP_NUM * SINE_LEN) / RATE_HZ;
    localparam int SETTLE_CYCLES = 40;
    localparam int PRINT_LIMIT   = 40;
    localparam real TWO_PI       = 6.28318530717958647692;

    // Index 3 has no register behind it; writes there must be ignored.
    localparam t_cfg_idx CFG_UNUSED = 2'd3;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    t_cfg_idx              i_cfg_idx       = CFG_ENABLE;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [31:0]           i_s_axis_tdata  = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [31:0]           o_m_axis_tdata;

    lfo_modulated_delay_chorus_unit #(
        .DELAY_DEPTH   (DELAY_WORDS),
        .LFO_TABLE_LEN (SINE_LEN),
        .SAMPLE_RATE_HZ(RATE_HZ)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [31:0]        delay_mem [DELAY_WORDS];
    logic signed [15:0] sine_rom  [SINE_LEN];
    int                 wr_pos;
    logic [23:0]        lfo_acc;
    logic               cfg_en;
    logic [6:0]         cfg_rate;
    logic [6:0]         cfg_depth;

    logic [31:0] expected_samples [$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;

    function automatic logic signed [15:0] sine_round(input int k);
        real s;
        int  mag;
        s   = $sin(TWO_PI * real'(k) / real'(SINE_LEN));
        mag = $rtoi(32767.0 * ((s < 0.0) ? -s : s) + 0.5);
        return (s < 0.0) ? 16'(-mag) : 16'(mag);
    endfunction

    function automatic logic [31:0] chorus_predict(input logic [31:0] x);
        int          ctr;
        int          span;
        logic [7:0]  idx;
        logic [7:0]  nidx;
        longint      ofs_a, ofs_b, tap_a, tap_b, up_a, up_b;
        longint      frac_w, rest_w, wet, dry, res;
        if (!cfg_en) begin
            return x;
        end
        ctr  = ((int'(cfg_depth) * DELAY_WORDS) >> 7) / 2;
        span = 2 * ctr + 1;
        wr_pos = (wr_pos == 0) ? 2 * ctr : wr_pos - 1;
        delay_mem[wr_pos % DELAY_WORDS] = x;

        // The table has 256 entries, so the 8-bit index wraps by itself.
        idx    = lfo_acc[23:16];
        nidx   = idx + 8'd1;
        ofs_a  = (longint'(sine_rom[idx]) * ctr) >>> 15;
        ofs_b  = (longint'(sine_rom[nidx]) * ctr) >>> 15;
        tap_a  = (wr_pos + ofs_a + ctr) % span;
        tap_b  = (wr_pos + ofs_b + ctr) % span;
        up_a   = $signed(delay_mem[tap_a % DELAY_WORDS][31:16]);
        up_b   = $signed(delay_mem[tap_b % DELAY_WORDS][31:16]);
        frac_w = lfo_acc[15:0];
        rest_w = FRAC_ONE - lfo_acc[15:0];
        wet    = up_a * rest_w + up_b * frac_w;

        lfo_acc = lfo_acc + 24'(LFO_STEP * int'(cfg_rate));

        dry = $signed(x);
        res = wet / 2 + dry / 2;
        return res[31:0];
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
    endtask

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected beat sample_out=%h", o_m_axis_tdata));
            end else begin
                want = expected_samples.pop_front();
                if (o_m_axis_tdata !== want) begin
                    report_mismatch($sformatf("sample_out got %h expected %h",
                                              o_m_axis_tdata, want));
                end
            end
        end
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [6:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLE: cfg_en    = val[0];
            CFG_RATE:   cfg_rate  = val;
            CFG_DEPTH:  cfg_depth = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [31:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        expected_samples.push_back(chorus_predict(s));
    endtask

    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return {($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic pick_settings();
        write_reg(CFG_ENABLE, {6'($urandom), 1'($urandom_range(7) != 0)});
        write_reg(CFG_RATE, ($urandom_range(1) != 0) ? 7'd127 : 7'($urandom_range(127)));
        case ($urandom_range(3))
            0: write_reg(CFG_DEPTH, 7'($urandom_range(4)));
            1: write_reg(CFG_DEPTH, 7'd127);
            default: write_reg(CFG_DEPTH, 7'($urandom_range(127)));
        endcase
        if ($urandom_range(3) == 0) begin
            write_reg(CFG_UNUSED, 7'($urandom));
        end
    endtask

    task automatic test_bypass();
        write_reg(CFG_ENABLE, 7'h7E);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0001_0000);
        settle();
    endtask

    task automatic test_chorus_extremes();
        write_reg(CFG_ENABLE, 7'h01);
        write_reg(CFG_RATE, 7'd127);
        write_reg(CFG_DEPTH, 7'd127);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_0000);
        send_sample(32'h8000_0001);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0001);
        settle();
    endtask

    // The write position is left far above the new, shorter line length.
    task automatic test_depth_shrink();
        write_reg(CFG_DEPTH, 7'd1);
        write_reg(CFG_RATE, 7'd0);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h1234_5678);
        send_sample(32'hFEDC_BA98);
        settle();
        write_reg(CFG_DEPTH, 7'd0);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h0000_FFFF);
        settle();
        write_reg(CFG_UNUSED, 7'h00);
        send_sample(32'h4000_0000);
        send_sample(32'hC000_0000);
        settle();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            if (n % 90 == 0) begin
                settle();
                pick_settings();
            end
            send_sample(pick_sample());
        end
        settle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Runs at the fastest LFO rate with a random depth.
    task automatic test_fast_lfo();
        write_reg(CFG_ENABLE, 7'h01);
        write_reg(CFG_RATE, 7'd127);
        write_reg(CFG_DEPTH, 7'($urandom_range(127)));
        repeat (20) send_sample($urandom);
        repeat (40) send_sample(pick_sample());
        settle();
    endtask

    initial begin
        for (int k = 0; k < SINE_LEN; k++) begin
            sine_rom[k] = sine_round(k);
        end
        for (int k = 0; k < DELAY_WORDS; k++) begin
            delay_mem[k] = '0;
        end
        wr_pos         = 0;
        lfo_acc        = '0;
        cfg_en         = ENABLE_RST;
        cfg_rate       = RATE_RST;
        cfg_depth      = DEPTH_RST;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_bypass();
        test_chorus_extremes();
        test_depth_shrink();
        test_random_traffic(0, 0, 450);
        test_random_traffic(73, 0, 450);
        test_random_traffic(0, 73, 450);
        test_random_traffic(30, 30, 450);
        test_fast_lfo();

        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ lfo_modulated_delay_chorus_unit.f @@
rtl/core/lmdc_pkg.sv
rtl/core/lmdc_urem.sv
rtl/core/lfo_modulated_delay_chorus_unit.sv
tb/testbench.sv
